[hw/rtl/rcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared constants, record type and glyph tables of the column shader.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int MAX_ROWS      = 64;
    localparam int ROW_W         = $clog2(MAX_ROWS);        // row index bits
    localparam int HGT_W         = $clog2(MAX_ROWS + 1);    // height / row count bits
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] RESET_HEIGHT = 7'd24;
    localparam logic [6:0] MIN_HEIGHT   = 7'd2;
    localparam logic [6:0] MAX_HEIGHT   = 7'(MAX_ROWS);

    localparam logic [3:0]  WALL_STEPS  = 4'd11;
    localparam logic [15:0] FAR_RAW     = 16'd4096;
    localparam logic [15:0] NEAR_RAW    = 16'd256;        // at or below: full height
    localparam int          QUO_W       = ROW_W;          // quotient bits when dist > 256
    localparam int          FLOOR_CUTS  = 5;

    localparam logic [6:0] CH_SPACE = 7'h20;

    // one classified column, handed from front to back
    typedef struct packed {
        logic [7:0]        column;
        logic [ROW_W-1:0]  row_last;
        logic [HGT_W-1:0]  wall_start;
        logic [HGT_W-1:0]  wall_end;
        logic [6:0]        wall_glyph;
        logic [FLOOR_CUTS-1:0][HGT_W-1:0] floor_cut;
    } t_col_rec;

    function automatic logic [6:0] wall_ramp(input logic [3:0] idx);
        logic [6:0] ch;
        case (idx)
            4'd0:    ch = 7'h40;  // @
            4'd1:    ch = 7'h25;  // %
            4'd2:    ch = 7'h23;  // #
            4'd3:    ch = 7'h2A;  // *
            4'd4:    ch = 7'h2B;  // +
            4'd5:    ch = 7'h3D;  // =
            4'd6:    ch = 7'h7E;  // ~
            4'd7:    ch = 7'h2D;  // -
            4'd8:    ch = 7'h3A;  // :
            4'd9:    ch = 7'h2E;  // .
            4'd10:   ch = 7'h60;  // `
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] floor_ramp(input logic [2:0] idx);
        logic [6:0] ch;
        case (idx)
            3'd0:    ch = CH_SPACE;
            3'd1:    ch = 7'h2E;  // .
            3'd2:    ch = 7'h3A;  // :
            3'd3:    ch = 7'h2D;  // -
            3'd4:    ch = 7'h3D;  // =
            default: ch = 7'h2B;  // +
        endcase
        return ch;
    endfunction

    // floor(x/5) for any 8-bit x, by reciprocal multiply
    function automatic logic [7:0] div5(input logic [7:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:10];
    endfunction

endpackage

[hw/rtl/rcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_front
// Takes a ray result, finds the slice height with a radix-2 divider and
// packs the row boundaries and glyphs into one column record.
// ----------------------------------------------------------------------------
module rcs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [6:0]         i_screen_height,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_column_index,
    input  logic               i_ray_hit,
    input  logic [15:0]        i_wall_distance,
    input  logic               i_side_is_y,
    output logic               o_push,
    output rcs_pkg::t_col_rec  o_rec,
    input  logic               i_full
);
    import rcs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam int REM_W = HGT_W + 8;
    localparam int SH_W  = 16 + QUO_W - 1;

    logic               r_valid;
    logic               r_div_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [7:0]         r_col;
    logic               r_hit;
    logic [15:0]        r_dist;
    logic               r_side;
    logic [HGT_W-1:0]   r_h;

    logic               w_accept;
    logic [HGT_W-1:0]   w_h_clamp;
    logic               w_need_div;
    logic [SH_W-1:0]    w_dsh;
    logic               w_fits;
    logic [HGT_W-1:0]   w_line;
    logic [HGT_W-1:0]   w_start;
    logic [12:0]        w_dclamp;
    logic [16:0]        w_dmul;
    logic [3:0]         w_idx;
    logic [ROW_W-1:0]   w_horizon;
    logic [FLOOR_CUTS-1:0][HGT_W-1:0] w_cut;

    always_comb begin
        if (i_screen_height < MIN_HEIGHT) begin
            w_h_clamp = HGT_W'(MIN_HEIGHT);
        end else if (i_screen_height > MAX_HEIGHT) begin
            w_h_clamp = HGT_W'(MAX_HEIGHT);
        end else begin
            w_h_clamp = HGT_W'(i_screen_height);
        end
    end

    assign w_need_div = i_ray_hit && (i_wall_distance > NEAR_RAW);
    assign w_dsh      = SH_W'(r_dist) << r_cnt;
    assign w_fits     = SH_W'(r_rem) >= w_dsh;

    // classification of the held item
    always_comb begin
        if (!r_hit) begin
            w_line = '0;
        end else if (r_dist > NEAR_RAW) begin
            w_line = HGT_W'(r_quo);
        end else begin
            w_line = r_h;
        end
        w_start  = (r_h - w_line) >> 1;
        w_dclamp = (r_dist > FAR_RAW) ? 13'(FAR_RAW) : r_dist[12:0];
        w_dmul   = 17'(w_dclamp) * 17'd11;
        w_idx    = r_hit ? w_dmul[15:12] : WALL_STEPS;
        if (r_side && w_idx < WALL_STEPS) begin
            w_idx = w_idx + 4'd1;
        end
        w_horizon = r_h[HGT_W-1:1];
        // row where the floor index first reaches k+1
        for (int k = 0; k < FLOOR_CUTS; k++) begin
            w_cut[k] = HGT_W'(w_horizon)
                     + HGT_W'(div5(8'(w_horizon) * 8'(k + 1) + 8'd4));
        end
    end

    assign o_push     = r_valid && !r_div_busy && !i_full;
    assign o_in_stall = r_valid && !o_push;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_rec.column     = r_col;
    assign o_rec.row_last   = ROW_W'(r_h - HGT_W'(1));
    assign o_rec.wall_start = w_start;
    assign o_rec.wall_end   = w_start + w_line;
    assign o_rec.wall_glyph = wall_ramp(w_idx);
    assign o_rec.floor_cut  = w_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_div_busy <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (w_accept) begin
                r_valid    <= 1'b1;
                r_div_busy <= w_need_div;
                r_cnt      <= CNT_W'(QUO_W - 1);
            end else begin
                if (o_push) begin
                    r_valid <= 1'b0;
                end
                if (r_div_busy) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_div_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col  <= i_column_index;
            r_hit  <= i_ray_hit;
            r_dist <= i_wall_distance;
            r_side <= i_side_is_y;
            r_h    <= w_h_clamp;
            r_rem  <= {w_h_clamp, 8'h00};
            r_quo  <= '0;
        end else if (r_div_busy && w_fits) begin
            // restoring step, one quotient bit per cycle
            r_rem        <= r_rem - REM_W'(w_dsh);
            r_quo[r_cnt] <= 1'b1;
        end
    end

endmodule

[hw/rtl/rcs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_queue
// Small first-in first-out buffer of column records between front and back.
// ----------------------------------------------------------------------------
module rcs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rcs_pkg::t_col_rec  i_rec,
    output logic               o_full,
    input  logic               i_pop,
    output rcs_pkg::t_col_rec  o_rec,
    output logic               o_empty
);
    import rcs_pkg::*;

    t_col_rec            r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_rec   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

endmodule

[hw/rtl/rcs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_back
// Walks the rows of one column record and emits one glyph beat per row
// through an output register.
// ----------------------------------------------------------------------------
module rcs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcs_pkg::t_col_rec  i_rec,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_column,
    output logic [5:0]         o_out_row,
    output logic [6:0]         o_glyph,
    output logic               o_last_row
);
    import rcs_pkg::*;

    logic               r_busy;
    t_col_rec           r_rec;
    logic [ROW_W-1:0]   r_row;
    logic               r_out_valid;
    logic [7:0]         r_out_column;
    logic [ROW_W-1:0]   r_out_row;
    logic [6:0]         r_glyph;
    logic               r_last_row;

    logic               w_advance;
    logic               w_row_last;
    logic [HGT_W-1:0]   w_row_ext;
    logic [2:0]         w_fidx;
    logic [6:0]         n_glyph;

    assign w_advance  = r_busy && (!r_out_valid || !i_out_stall);
    assign w_row_last = r_row == r_rec.row_last;
    assign o_pop      = !i_empty && (!r_busy || (w_advance && w_row_last));
    assign w_row_ext  = HGT_W'(r_row);

    always_comb begin
        w_fidx = '0;
        for (int k = 0; k < FLOOR_CUTS; k++) begin
            if (w_row_ext >= r_rec.floor_cut[k]) begin
                w_fidx = w_fidx + 3'd1;
            end
        end
        if (w_row_ext < r_rec.wall_start) begin
            n_glyph = CH_SPACE;
        end else if (w_row_ext < r_rec.wall_end) begin
            n_glyph = r_rec.wall_glyph;
        end else begin
            n_glyph = floor_ramp(w_fidx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (w_advance) begin
                if (w_row_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (w_advance) begin
            r_out_column <= r_rec.column;
            r_out_row    <= r_row;
            r_glyph      <= n_glyph;
            r_last_row   <= w_row_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_column = r_out_column;
    assign o_out_row    = 6'(r_out_row);
    assign o_glyph      = r_glyph;
    assign o_last_row   = r_last_row;

endmodule

[hw/rtl/raycast_column_shader_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_shader_unit
// Turns one screen column's ray result into one text glyph per screen row.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) takes one column per beat:
//   column index, hit flag, Q8.8 wall distance and wall side
//   output channel (o_out_valid / i_out_stall) gives H beats per column,
//   top row first, with o_last_row set on row H-1; H is screen_height
//   limited to 2..64
//   screen_height is written through i_cfg_wr_en / i_cfg_wr_data; the user
//   writes it only while the unit is idle, not enforced here; reset loads 24
//   first row path: front register, queue slot, row walker record, output
//   register; a hit at a distance above 1.0 also runs the divider first
//   flow: the row walker emits one beat per cycle while the output is not
//   stalled; the front holds one column and takes the next as it pushes the
//   held one, and a two-entry queue lets it work ahead of the row walker
//   a stall on the output holds the output register; the queue and the
//   front keep filling until full, then o_in_stall rises
//   synchronous active-low reset empties every stage; no clearing pass
// ----------------------------------------------------------------------------
module raycast_column_shader_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_column_index,
    input  logic        i_ray_hit,
    input  logic [15:0] i_wall_distance,
    input  logic        i_side_is_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_column,
    output logic [5:0]  o_out_row,
    output logic [6:0]  o_glyph,
    output logic        o_last_row
);
    import rcs_pkg::*;

    logic [6:0] r_screen_height;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_col_rec   w_front_rec;
    t_col_rec   w_head_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= RESET_HEIGHT;
        end else if (i_cfg_wr_en) begin
            r_screen_height <= i_cfg_wr_data;
        end
    end

    rcs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_screen_height (r_screen_height),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_column_index  (i_column_index),
        .i_ray_hit       (i_ray_hit),
        .i_wall_distance (i_wall_distance),
        .i_side_is_y     (i_side_is_y),
        .o_push          (w_push),
        .o_rec           (w_front_rec),
        .i_full          (w_full)
    );

    rcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_empty (w_empty)
    );

    rcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (w_head_rec),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_glyph      (o_glyph),
        .o_last_row   (o_last_row)
    );

endmodule

[verif/rcs_glyph_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_glyph_checker
// Watches both channels of the column shader. It predicts the glyph of every
// row of each column taken in, and compares each output beat, field by field,
// with the oldest cell still expected.
// ----------------------------------------------------------------------------
module rcs_glyph_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_column_index,
    input  logic        i_ray_hit,
    input  logic [15:0] i_wall_distance,
    input  logic        i_side_is_y,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_column,
    input  logic [5:0]  i_out_row,
    input  logic [6:0]  i_glyph,
    input  logic        i_last_row,
    output int          o_fail_count,
    output int          o_cells_pending
);
    import rcs_pkg::*;

    typedef struct packed {
        logic [7:0] column;
        logic [5:0] row;
        logic [6:0] glyph;
        logic       last;
    } t_cell;

    localparam int unsigned LIGHTEST_WALL = 11;
    localparam int unsigned FLOOR_TOP     = 5;

    // dense to light; index 10 is the grave accent
    localparam logic [0:11][6:0] WALL_SHADES = {
        7'h40, 7'h25, 7'h23, 7'h2A, 7'h2B, 7'h3D,
        7'h7E, 7'h2D, 7'h3A, 7'h2E, 7'h60, 7'h20
    };
    localparam logic [0:5][6:0] FLOOR_SHADES = {
        7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B
    };

    logic [6:0] height_reg;
    t_cell      cell_q [$];

    function automatic int unsigned rows_for(input logic [6:0] h);
        if (h < MIN_HEIGHT) return MIN_HEIGHT;
        if (h > MAX_HEIGHT) return MAX_HEIGHT;
        return h;
    endfunction

    function automatic logic [6:0] cell_glyph(input int unsigned rows, input int unsigned y,
                                              input logic hit, input logic [15:0] wall_dist,
                                              input logic side_y);
        int unsigned horizon;
        int unsigned span;
        int unsigned top;
        int unsigned shade;
        int unsigned depth;
        horizon = rows / 2;
        span    = 0;
        if (hit) begin
            span = (rows * 256) / ((wall_dist == 0) ? 1 : wall_dist);
            if (span > rows) span = rows;
        end
        top = (rows - span) / 2;
        if (!hit) begin
            shade = LIGHTEST_WALL;
        end else begin
            shade = (((wall_dist > FAR_RAW) ? FAR_RAW : wall_dist) * WALL_STEPS) / FAR_RAW;
        end
        // y-side faces are one step lighter
        if (side_y && shade < LIGHTEST_WALL) shade++;
        if (y < top) return CH_SPACE;
        if (y < top + span) return WALL_SHADES[shade];
        depth = 0;
        if (y >= horizon) begin
            depth = ((y - horizon) * FLOOR_CUTS) / horizon;
            if (depth > FLOOR_TOP) depth = FLOOR_TOP;
        end
        return FLOOR_SHADES[depth];
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cell       want;
        int unsigned rows;
        if (!i_rst_n) begin
            height_reg   = RESET_HEIGHT;
            o_fail_count = 0;
            cell_q.delete();
        end else begin
            if (i_cfg_wr_en) height_reg = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                rows = rows_for(height_reg);
                for (int unsigned y = 0; y < rows; y++) begin
                    want.column = i_column_index;
                    want.row    = y[5:0];
                    want.glyph  = cell_glyph(rows, y, i_ray_hit, i_wall_distance,
                                             i_side_is_y);
                    want.last   = (y == rows - 1);
                    cell_q.push_back(want);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (cell_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual col %0d row %0d",
                             $time, i_out_column, i_out_row);
                    o_fail_count++;
                end else begin
                    want = cell_q.pop_front();
                    check_field("out_column", want.column, i_out_column);
                    check_field("out_row", want.row, i_out_row);
                    check_field("glyph", want.glyph, i_glyph);
                    check_field("last_row", want.last, i_last_row);
                end
            end
        end
        o_cells_pending = cell_q.size();
    end

endmodule

[verif/raycast_column_shader_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_shader_unit_tb
// Feeds ray results into the column shader across a sweep of screen heights,
// in and beyond the legal range, with random gaps and stalls on both sides and
// one long output hold-off; the checker beside the unit scores every row.
// ----------------------------------------------------------------------------
module raycast_column_shader_unit_tb;
    import rcs_pkg::*;

    localparam int ITEMS_PER_PHASE = 39;
    localparam int PHASES          = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int QUIET_LIMIT     = 2000;

    // last phase picks its height at random
    localparam logic [0:PHASES-1][6:0] PHASE_HEIGHTS = {
        7'd0, 7'd127, 7'd64, 7'd2, 7'd1, 7'd65, 7'd3, 7'd24, 7'd40, 7'd17
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_column_index;
    logic        i_ray_hit;
    logic [15:0] i_wall_distance;
    logic        i_side_is_y;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_column;
    logic [5:0]  o_out_row;
    logic [6:0]  o_glyph;
    logic        o_last_row;

    int   fail_count;
    int   cells_pending;
    int   snd_idle_pct = 6;
    int   rcv_idle_pct = 67;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    raycast_column_shader_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_column_index  (i_column_index),
        .i_ray_hit       (i_ray_hit),
        .i_wall_distance (i_wall_distance),
        .i_side_is_y     (i_side_is_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_glyph         (o_glyph),
        .o_last_row      (o_last_row)
    );

    rcs_glyph_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_column_index  (i_column_index),
        .i_ray_hit       (i_ray_hit),
        .i_wall_distance (i_wall_distance),
        .i_side_is_y     (i_side_is_y),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_column    (o_out_column),
        .i_out_row       (o_out_row),
        .i_glyph         (o_glyph),
        .i_last_row      (o_last_row),
        .o_fail_count    (fail_count),
        .o_cells_pending (cells_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // output side: one long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("raycast_column_shader_unit_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_column(input logic [7:0] col, input logic hit,
                               input logic [15:0] wall_dist, input logic side_y);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_column_index  <= col;
        i_ray_hit       <= hit;
        i_wall_distance <= wall_dist;
        i_side_is_y     <= side_y;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random(input int unsigned rows);
        logic [15:0] wall_dist;
        case ($urandom_range(3))
            0:       wall_dist = 16'($urandom_range(600));
            // around the distance where the slice shrinks from one row to none
            1:       wall_dist = 16'(rows * 256 - 300 + $urandom_range(600));
            2:       wall_dist = 16'($urandom_range(4300));
            default: wall_dist = 16'($urandom);
        endcase
        send_column(8'($urandom), $urandom_range(99) < 88, wall_dist, 1'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (cells_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_height(input logic [6:0] h);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= h;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [6:0]  h;
        int unsigned rows;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_in_valid      <= 1'b0;
        i_column_index  <= '0;
        i_ray_hit       <= 1'b0;
        i_wall_distance <= '0;
        i_side_is_y     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed columns at the reset height of 24 rows
        send_column(8'd0,   1'b0, 16'd0,     1'b0);  // missed ray
        send_column(8'd255, 1'b0, 16'hFFFF,  1'b1);  // missed ray, y side
        send_column(8'd1,   1'b1, 16'd0,     1'b0);  // zero distance
        send_column(8'd2,   1'b1, 16'd0,     1'b1);
        send_column(8'd3,   1'b1, 16'd1,     1'b0);
        send_column(8'd4,   1'b1, 16'd256,   1'b0);  // last full-height distance
        send_column(8'd5,   1'b1, 16'd257,   1'b0);
        send_column(8'd6,   1'b1, 16'd372,   1'b0);  // darkest shade edge
        send_column(8'd7,   1'b1, 16'd373,   1'b0);
        send_column(8'd8,   1'b1, 16'd4095,  1'b1);  // y side pushes to blank
        send_column(8'd9,   1'b1, 16'd4096,  1'b0);  // sixteen units
        send_column(8'd10,  1'b1, 16'd4097,  1'b1);  // beyond sixteen, saturated
        send_column(8'd11,  1'b1, 16'd6144,  1'b0);  // one-row slice
        send_column(8'd12,  1'b1, 16'd6145,  1'b0);  // hit but no slice
        send_column(8'd13,  1'b1, 16'hFFFF,  1'b1);
        send_column(8'd14,  1'b1, 16'd3000,  1'b1);
        send_column(8'h55,  1'b1, 16'd1024,  1'b0);
        send_column(8'hAA,  1'b1, 16'd2048,  1'b1);

        for (int p = 0; p < PHASES; p++) begin
            h = (p == PHASES - 1) ? 7'($urandom_range(127)) : PHASE_HEIGHTS[p];
            if (p == 4) begin
                snd_idle_pct <= 67;
                rcv_idle_pct <= 6;
            end
            if (p == 7) begin
                snd_idle_pct <= 0;
                rcv_idle_pct <= 0;
            end
            set_height(h);
            rows = (h < MIN_HEIGHT) ? MIN_HEIGHT : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
            // hold the output back while columns keep coming, to fill the queue
            if (p == 2) hold_req <= 1'b1;
            repeat (ITEMS_PER_PHASE) send_random(rows);
        end

        wait_drained();
        if (fail_count == 0 && cells_pending == 0) begin
            $display("raycast_column_shader_unit_tb OK");
        end else begin
            $display("raycast_column_shader_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

[raycast_column_shader_unit.f]
hw/rtl/rcs_pkg.sv
hw/rtl/rcs_front.sv
hw/rtl/rcs_queue.sv
hw/rtl/rcs_back.sv
hw/rtl/raycast_column_shader_unit.sv
verif/rcs_glyph_checker.sv
verif/raycast_column_shader_unit_tb.sv
